// ===== sv/dhb_pkg.sv =====
package dhb_pkg;

   localparam int PWM_STEPS_DEF = 64;

   typedef struct packed {
      logic       action;
      logic [2:0] motion_command;
      logic [1:0] drive_level;
   } req_type;

   typedef struct packed {
      logic [7:0] bridge_pins;
      logic [5:0] phase_now;
   } rsp_type;

   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_COMMAND = 1'b1;

   localparam logic [2:0] CMD_FORWARD     = 3'd0;
   localparam logic [2:0] CMD_RIGHT       = 3'd1;
   localparam logic [2:0] CMD_LEFT        = 3'd2;
   localparam logic [2:0] CMD_STOP        = 3'd3;
   localparam logic [2:0] CMD_BACKWARD    = 3'd4;
   localparam logic [2:0] CMD_SHARP_RIGHT = 3'd5;
   localparam logic [2:0] CMD_SHARP_LEFT  = 3'd6;
   localparam logic [2:0] CMD_NONE        = 3'd7;

   localparam logic [1:0] MODE_FORWARD = 2'd0;
   localparam logic [1:0] MODE_RIGHT   = 2'd1;
   localparam logic [1:0] MODE_LEFT    = 2'd2;
   localparam logic [1:0] MODE_STOP    = 2'd3;

   localparam logic [1:0] LEVEL_KEEP = 2'd0;
   localparam logic [1:0] LEVEL_1    = 2'd1;
   localparam logic [1:0] LEVEL_2    = 2'd2;
   localparam logic [1:0] LEVEL_3    = 2'd3;

   localparam logic [7:0] PINS_RESET   = 8'hFF;
   localparam logic [7:0] PINS_OFF     = 8'h00;
   localparam logic [7:0] LEFT_DRIVE   = 8'h12;
   localparam logic [7:0] LEFT_REV     = 8'h21;
   localparam logic [7:0] RIGHT_DRIVE  = 8'h44;
   localparam logic [7:0] RIGHT_REV    = 8'h88;
   localparam logic [7:0] PAT_BACK     = 8'hA9;
   localparam logic [7:0] PAT_SHARP_R  = 8'h9A;
   localparam logic [7:0] PAT_SHARP_L  = 8'h65;

   localparam logic [5:0] DUTY_RESET = 6'd32;
   localparam logic [5:0] DUTY_LOW   = 6'd16;
   localparam logic [5:0] DUTY_MID   = 6'd32;
   localparam logic [5:0] DUTY_HIGH  = 6'd48;
   localparam logic [5:0] DUTY_FULL  = 6'd63;

   typedef struct packed {
      logic [5:0] left_duty;
      logic [5:0] right_duty;
      logic       flip;
   } duty_set_type;

   // Duty and flip for a soft turn; level must be 1..3.
   function automatic duty_set_type turn_set(logic is_right, logic [1:0] level);
      duty_set_type s;
      s = '{left_duty: DUTY_HIGH, right_duty: DUTY_HIGH, flip: 1'b1};
      unique case (level)
         LEVEL_1: s = is_right ? duty_set_type'{DUTY_HIGH, DUTY_MID, 1'b0}
                               : duty_set_type'{DUTY_MID, DUTY_HIGH, 1'b0};
         LEVEL_2: s = is_right ? duty_set_type'{DUTY_HIGH, DUTY_MID, 1'b1}
                               : duty_set_type'{DUTY_MID, DUTY_HIGH, 1'b1};
         default: s = duty_set_type'{DUTY_HIGH, DUTY_HIGH, 1'b1};
      endcase
      return s;
   endfunction

   function automatic logic [5:0] forward_duty(logic [1:0] level);
      logic [5:0] d;
      d = DUTY_MID;
      unique case (level)
         LEVEL_1: d = DUTY_LOW;
         LEVEL_3: d = DUTY_FULL;
         default: d = DUTY_MID;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/dhb_core.sv =====
module dhb_core #(
   parameter int PWM_STEPS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  dhb_pkg::req_type item,
   output dhb_pkg::rsp_type result
);
   import dhb_pkg::*;

   localparam int PW = $clog2(PWM_STEPS);

   logic [PW-1:0] phase_ff, phase_in;
   logic [1:0]    mode_ff, mode_in;
   logic          fixed_ff, fixed_in;
   logic          flip_ff, flip_in;
   logic [5:0]    left_duty_ff, left_duty_in;
   logic [5:0]    right_duty_ff, right_duty_in;
   logic [7:0]    pins_ff, pins_in;
   logic [PW-1:0] phase_next;
   duty_set_type  turn;
   logic [7:0]    tick_pins;

   assign phase_next = (phase_ff == PW'(PWM_STEPS - 1)) ? '0 : phase_ff + 1'b1;
   assign turn = turn_set(item.motion_command == CMD_RIGHT, item.drive_level);

   always_comb begin
      tick_pins = PINS_OFF;
      if (phase_next < PW'(left_duty_ff)) begin
         tick_pins = tick_pins | ((flip_ff && mode_ff == MODE_LEFT) ? LEFT_REV : LEFT_DRIVE);
      end
      if (phase_next < PW'(right_duty_ff)) begin
         tick_pins = tick_pins | ((flip_ff && mode_ff == MODE_RIGHT) ? RIGHT_REV : RIGHT_DRIVE);
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      mode_in       = mode_ff;
      fixed_in      = fixed_ff;
      flip_in       = flip_ff;
      left_duty_in  = left_duty_ff;
      right_duty_in = right_duty_ff;
      pins_in       = pins_ff;
      if (fire) begin
         if (item.action == ACT_TICK) begin
            phase_in = phase_next;
            // hold pins while stopped or a fixed pattern is latched
            if (!(mode_ff == MODE_STOP || fixed_ff)) begin
               pins_in = tick_pins;
            end
         end else begin
            unique case (item.motion_command)
               CMD_FORWARD: begin
                  mode_in  = MODE_FORWARD;
                  fixed_in = 1'b0;
                  if (item.drive_level != LEVEL_KEEP) begin
                     left_duty_in  = forward_duty(item.drive_level);
                     right_duty_in = forward_duty(item.drive_level);
                  end
               end
               CMD_RIGHT, CMD_LEFT: begin
                  mode_in  = (item.motion_command == CMD_RIGHT) ? MODE_RIGHT : MODE_LEFT;
                  fixed_in = 1'b0;
                  if (item.drive_level != LEVEL_KEEP) begin
                     left_duty_in  = turn.left_duty;
                     right_duty_in = turn.right_duty;
                     flip_in       = turn.flip;
                  end
               end
               CMD_STOP: begin
                  mode_in  = MODE_STOP;
                  fixed_in = 1'b0;
                  pins_in  = PINS_OFF;
               end
               CMD_BACKWARD: begin
                  fixed_in = 1'b1;
                  pins_in  = PAT_BACK;
               end
               CMD_SHARP_RIGHT: begin
                  fixed_in = 1'b1;
                  pins_in  = PAT_SHARP_R;
               end
               CMD_SHARP_LEFT: begin
                  fixed_in = 1'b1;
                  pins_in  = PAT_SHARP_L;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         mode_ff       <= MODE_FORWARD;
         fixed_ff      <= 1'b0;
         flip_ff       <= 1'b0;
         left_duty_ff  <= DUTY_RESET;
         right_duty_ff <= DUTY_RESET;
         pins_ff       <= PINS_RESET;
      end else begin
         phase_ff      <= phase_in;
         mode_ff       <= mode_in;
         fixed_ff      <= fixed_in;
         flip_ff       <= flip_in;
         left_duty_ff  <= left_duty_in;
         right_duty_ff <= right_duty_in;
         pins_ff       <= pins_in;
      end
   end

   assign result.bridge_pins = pins_in;
   assign result.phase_now   = phase_in[5:0];

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff < PW'(PWM_STEPS - 1) || phase_ff == PW'(PWM_STEPS - 1))
      else $error("phase counter beyond its wrap point");

   a_cmd_keeps_phase: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == ACT_COMMAND |=> $stable(phase_ff))
      else $error("command beat moved the phase");

   a_stop_holds_pins: assert property (@(posedge clock) disable iff (reset)
      fire && item.action == ACT_TICK && (mode_ff == MODE_STOP || fixed_ff)
      |=> $stable(pins_ff))
      else $error("tick changed held pins");

endmodule

// ===== sv/dual_hbridge_pwm_drive_top.sv =====
// Dual H-bridge PWM drive.
// Input channel req_*: one beat is either a PWM tick (action = 0) or a motion
// command (action = 1, with motion_command and drive_level). Every beat gives
// exactly one result beat on rsp_*: the eight bridge pin levels and the low
// six bits of the PWM phase after that beat.
// Path: an accepted beat sits in the input register, then is applied to the
// drive state and captured in the result register once that register can
// advance, which raises rsp_valid.
// Throughput: one beat per cycle while rsp_ready stays high; the state update is one compare per side
// and a pattern mux between the input and result registers.
// Reset: phase 0, forward mode, both duties 32, no flip, all pins high.
// Stall: while rsp_ready is low the result register holds; the input register
// still takes one more beat, then req_ready drops until rsp_ready returns.
module dual_hbridge_pwm_drive_top #(
   parameter int PWM_STEPS = dhb_pkg::PWM_STEPS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dhb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dhb_pkg::rsp_type rsp_data
);
   import dhb_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type result;
   logic    advance;
   logic    fire;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   dhb_core #(
      .PWM_STEPS(PWM_STEPS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result beat without a staged request");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

   a_fire_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("applied beat lost before result register");

endmodule
